// File: src/pip_pkg.sv
package pip_pkg;
  localparam int MAX_VERTICES_DEF = 256;
  localparam int COORD_BITS_DEF = 16;
  localparam int IDX_BITS = 8;
  localparam int CFG_ADDR_BITS = 1;
  localparam int CFG_DATA_BITS = 8;
  localparam logic [CFG_ADDR_BITS-1:0] REG_GEOMETRY_TYPE = 1'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_VERTEX_COUNT = 1'd1;

  typedef enum logic [1:0] {
    GEO_POINT    = 2'd0,
    GEO_POLYLINE = 2'd1,
    GEO_POLYGON  = 2'd2,
    GEO_UNKNOWN  = 2'd3
  } geo_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MULT,
    ST_DIV,
    ST_CMP,
    ST_DONE
  } state_t;
endpackage

// File: src/pip_ram.sv
module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: src/point_in_polygon_test.sv
// Vertex write request: written on acceptance, no response; writes can follow back to back.
// Query: the point type, the unknown type and a zero count are answered from the first read;
// ring types walk the edges in turn, and an edge that straddles the point's y adds a multiply,
// then a bit-serial divide and a compare. The next request is taken the cycle after the
// answer leaves. Reset (rst, synchronous) clears control; the vertex table is left unset.
module point_in_polygon_test
  import pip_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // mode[0], vertex_index[8:1], coord_x[24:9], coord_y[40:25], zero pad
  input  logic [(9 + 2*COORD_BITS + 7) / 8 * 8 - 1:0] s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // inside_res[0], zero pad
  output logic [7:0]               m_axis_tdata,
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CB = COORD_BITS;
  localparam int DW = CB + 2;         // signed difference width
  localparam int PW = 2 * DW;         // product width
  localparam int DCW = $clog2(PW + 1);

  // Configuration registers.
  geo_t            geometry_type;
  logic [7:0]      vertex_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      geometry_type <= GEO_POINT;
      vertex_count  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GEOMETRY_TYPE: geometry_type <= geo_t'(cfg_wdata[1:0]);
        REG_VERTEX_COUNT:  vertex_count  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Request fields.
  logic          in_mode;
  logic [7:0]    in_idx;
  logic [CB-1:0] in_x, in_y;
  assign in_mode = s_axis_tdata[0];
  assign in_idx  = s_axis_tdata[8:1];
  assign in_x    = s_axis_tdata[9 +: CB];
  assign in_y    = s_axis_tdata[9 + CB +: CB];

  state_t state, state_next;
  logic   accept;
  assign accept = s_axis_tvalid && s_axis_tready;

  // Query registers.
  logic [CB-1:0]  px, py;
  logic [7:0]     cnt;        // edges done
  logic [CB-1:0]  prev_x, prev_y;  // vertex j
  logic           have_prev;
  logic           c;
  logic           result;
  logic           m_valid;

  // Edge datapath registers.
  logic signed [PW-1:0] num;
  logic signed [DW-1:0] den;
  logic [PW-1:0]        rem, quo, dmag;
  logic                 qneg;
  logic [DCW-1:0]       dstep;
  logic [CB-1:0]        ax;
  logic [CB-1:0]        vy_hold;

  // RAM: {y, x}.
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [2*CB-1:0] ram_wdata, ram_rdata;

  assign ram_we    = accept && !in_mode;
  assign ram_waddr = AW'(in_idx);
  assign ram_wdata = {in_y, in_x};

  pip_ram #(.WIDTH(2*CB), .DEPTH(MAX_VERTICES)) u_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic [CB-1:0] vx, vy;
  assign vx = ram_rdata[CB-1:0];
  assign vy = ram_rdata[2*CB-1:CB];

  // The read address leads the registered RAM output: while idle fetch vertex 0 for the point type,
  // else vertex count-1 (the first edge's j); then vertex 0, then each next vertex i.
  always_comb begin
    if (state == ST_IDLE) begin
      ram_raddr = (geometry_type == GEO_POINT) ? '0 : AW'(vertex_count - 8'd1);
    end else if (!have_prev) begin
      ram_raddr = AW'(cnt);
    end else begin
      ram_raddr = AW'(cnt + 8'd1);
    end
  end

  logic straddle;
  assign straddle = ({1'b0, vy} >= {1'b0, py}) != ({1'b0, prev_y} >= {1'b0, py});

  logic signed [DW-1:0] dx, dy, da;
  assign dx = DW'(signed'({1'b0, prev_x})) - DW'(signed'({1'b0, vx}));
  assign dy = DW'(signed'({1'b0, py})) - DW'(signed'({1'b0, vy}));
  assign da = DW'(signed'({1'b0, prev_y})) - DW'(signed'({1'b0, vy}));

  // Restoring divide step on magnitudes.
  logic [PW-1:0] rem_sh;
  assign rem_sh = {rem[PW-2:0], quo[PW-1]};

  logic signed [PW+1:0] qsigned, lhs;
  assign qsigned = qneg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
  assign lhs = $signed({{(PW+2-CB){1'b0}}, px}) - $signed({{(PW+2-CB){1'b0}}, ax});

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && in_mode) state_next = ST_READ;
      ST_READ: begin
        if (geometry_type == GEO_POINT) state_next = ST_DONE;
        else if (geometry_type == GEO_UNKNOWN || vertex_count == 8'd0) state_next = ST_DONE;
        else if (!have_prev) state_next = ST_READ;
        else if (straddle) state_next = ST_MULT;
        else if (cnt == vertex_count - 8'd1) state_next = ST_DONE;
        else state_next = ST_READ;
      end
      ST_MULT: state_next = ST_DIV;
      ST_DIV:  if (dstep == DCW'(PW - 1)) state_next = ST_CMP;
      ST_CMP:  state_next = (cnt == vertex_count - 8'd1) ? ST_DONE : ST_READ;
      ST_DONE: if (!m_valid) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_valid <= 1'b0;
      have_prev <= 1'b0;
      cnt <= '0;
      c <= 1'b0;
    end else begin
      state <= state_next;
      if (m_valid && m_axis_tready) m_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          have_prev <= 1'b0;
          cnt <= '0;
          c <= 1'b0;
        end
        ST_READ: begin
          if (geometry_type == GEO_POINT) begin
            result <= (vx == px) && (vy == py);
          end else if (geometry_type == GEO_UNKNOWN || vertex_count == 8'd0) begin
            result <= 1'b0;
          end else if (!have_prev) begin
            have_prev <= 1'b1;
          end else begin
            // vx/vy is vertex i; prev is vertex j.
            ax <= vx;
            den <= da;
            num <= PW'(dx) * PW'(dy);
            if (!straddle) begin
              prev_x <= vx;
              prev_y <= vy;
              cnt <= cnt + 8'd1;
              result <= c;
            end
          end
          if (!have_prev) begin
            prev_x <= vx;
            prev_y <= vy;
          end
        end
        ST_MULT: begin
          qneg <= num[PW-1] ^ den[DW-1];
          quo  <= num[PW-1] ? PW'(-num) : PW'(num);
          dmag <= den[DW-1] ? PW'(-den) : PW'(den);
          rem  <= '0;
          dstep <= '0;
        end
        ST_DIV: begin
          dstep <= dstep + DCW'(1);
          if ({1'b0, rem_sh} >= {1'b0, dmag}) begin
            rem <= rem_sh - dmag;
            quo <= {quo[PW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[PW-2:0], 1'b0};
          end
        end
        ST_CMP: begin
          prev_x <= ax;
          prev_y <= vy_hold;
          cnt <= cnt + 8'd1;
          if (lhs <= qsigned) begin
            c <= !c;
            result <= !c;
          end else begin
            result <= c;
          end
        end
        ST_DONE: if (!m_valid) m_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // Hold vertex i's y across the divide.
  always_ff @(posedge clk) begin
    if (state == ST_READ) vy_hold <= vy;
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      px <= in_x;
      py <= in_y;
    end
  end

  assign s_axis_tready = (state == ST_IDLE) && !m_valid;
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {7'd0, result};

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_axis_tready) else $error("accept while busy");
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    (m_valid && !m_axis_tready) |=> $stable(result)) else $error("result changed");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> (cnt < vertex_count)) else $error("edge count overrun");
`endif
endmodule

// File: test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pip_pkg::*;

  localparam int NUM_ITEMS = 1150;
  localparam int RANDOM_ITEMS = NUM_ITEMS - 260;

  typedef enum logic [1:0] {ROW_CFG, ROW_WRITE, ROW_QUERY} row_kind_t;

  // One row of the directed table. For a register row idx holds the register index
  // and x the value. has_exp marks a query whose answer is typed in by hand.
  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  idx;
    logic [15:0] x;
    logic [15:0] y;
    logic        has_exp;
    logic        exp_inside;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  point_in_polygon_test u_dut (.*);

  always #5 clk = ~clk;

  // Shadow copy of the vertex table and registers.
  logic [15:0] shadow_x [256];
  logic [15:0] shadow_y [256];
  geo_t        shadow_geo;
  logic [7:0]  shadow_count;

  logic        inside_queue [$];
  int          fail_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          items_sent = 0;
  int          queries_sent = 0;
  int          writes_sent = 0;
  int          insides_seen = 0;
  int          results_seen = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  // Edge straddles the point's y and the point lies at or left of the intercept.
  function automatic bit edge_crosses(input logic [15:0] ax_u, ay_u, bx_u, by_u,
                                      input logic [15:0] px_u, py_u);
    longint ax, ay, bx, by, px, py, q;
    ax = ax_u; ay = ay_u; bx = bx_u; by = by_u; px = px_u; py = py_u;
    if ((ay >= py) == (by >= py)) return 1'b0;
    q = ((bx - ax) * (py - ay)) / (by - ay);
    return px <= q + ax;
  endfunction

  function automatic logic predict_inside(input logic [15:0] px, py);
    bit ring;
    int prev;
    ring = 1'b0;
    case (shadow_geo)
      GEO_POINT: return (px == shadow_x[0]) && (py == shadow_y[0]);
      GEO_POLYLINE, GEO_POLYGON: begin
        if (shadow_count == 0) return 1'b0;
        prev = shadow_count - 1;
        for (int i = 0; i < shadow_count; i++) begin
          if (edge_crosses(shadow_x[i], shadow_y[i], shadow_x[prev], shadow_y[prev], px, py))
            ring = ~ring;
          prev = i;
        end
        return ring;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Hold off until every answer is in and the block has gone quiet, then write.
  task automatic write_register(input logic [CFG_ADDR_BITS-1:0] addr, input logic [7:0] value);
    while (inside_queue.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (addr == REG_GEOMETRY_TYPE) shadow_geo = geo_t'(value[1:0]);
    else shadow_count = value;
  endtask

  // Present one request from a falling edge; valid stays high into the next request
  // unless an idle cycle is drawn. Returns at the falling edge after acceptance.
  task automatic send_request(input logic mode, input logic [7:0] idx,
                              input logic [15:0] x, y,
                              input logic has_exp, input logic exp_inside);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, y, x, idx, mode};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if (mode == 1'b0) begin
      shadow_x[idx] = x;
      shadow_y[idx] = y;
      writes_sent++;
    end else begin
      inside_queue.push_back(has_exp ? exp_inside : predict_inside(x, y));
      queries_sent++;
    end
    @(negedge clk);
  endtask

  task automatic idle_bus();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  // Receiver: draw stalls at the falling edge.
  always @(negedge clk)
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Check each answer against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (m_axis_tdata[0]) insides_seen++;
      if (inside_queue.size() == 0)
        report_mismatch("answer with no query outstanding");
      else if (m_axis_tdata[0] !== inside_queue[0]) begin
        report_mismatch($sformatf("inside_res got %b expected %b",
                                  m_axis_tdata[0], inside_queue[0]));
        void'(inside_queue.pop_front());
      end else
        void'(inside_queue.pop_front());
    end
  end

  dir_row_t directed [] = '{
    '{ROW_WRITE, 8'd0,   16'd100,   16'd100,   1'b0, 1'b0},
    '{ROW_WRITE, 8'd1,   16'd200,   16'd100,   1'b0, 1'b0},
    '{ROW_WRITE, 8'd2,   16'd200,   16'd200,   1'b0, 1'b0},
    '{ROW_WRITE, 8'd3,   16'd100,   16'd200,   1'b0, 1'b0},
    // point type straight after reset: equality with vertex 0
    '{ROW_QUERY, 8'd0,   16'd100,   16'd100,   1'b1, 1'b1},
    '{ROW_QUERY, 8'd255, 16'd101,   16'd100,   1'b1, 1'b0},
    '{ROW_CFG,   8'd0,   16'(GEO_POLYGON), 16'd0, 1'b0, 1'b0},
    // no edges while the count is zero
    '{ROW_QUERY, 8'd0,   16'd150,   16'd150,   1'b1, 1'b0},
    '{ROW_CFG,   8'd1,   16'd4,     16'd0,     1'b0, 1'b0},
    '{ROW_QUERY, 8'd0,   16'd150,   16'd150,   1'b1, 1'b1},
    '{ROW_QUERY, 8'd0,   16'd50,    16'd150,   1'b1, 1'b0},
    '{ROW_QUERY, 8'd0,   16'd0,     16'd0,     1'b1, 1'b0},
    '{ROW_QUERY, 8'd255, 16'd65535, 16'd65535, 1'b1, 1'b0},
    '{ROW_QUERY, 8'd0,   16'd100,   16'd150,   1'b0, 1'b0},
    '{ROW_CFG,   8'd0,   16'(GEO_POLYLINE), 16'd0, 1'b0, 1'b0},
    '{ROW_QUERY, 8'd0,   16'd150,   16'd150,   1'b0, 1'b0},
    '{ROW_CFG,   8'd0,   16'(GEO_UNKNOWN), 16'd0, 1'b0, 1'b0},
    '{ROW_QUERY, 8'd0,   16'd150,   16'd150,   1'b1, 1'b0},
    // coordinate extremes and the top table entry
    '{ROW_WRITE, 8'd4,   16'd0,     16'd65535, 1'b0, 1'b0},
    '{ROW_WRITE, 8'd255, 16'd65535, 16'd0,     1'b0, 1'b0},
    '{ROW_CFG,   8'd0,   16'(GEO_POLYGON), 16'd0, 1'b0, 1'b0},
    '{ROW_CFG,   8'd1,   16'd5,     16'd0,     1'b0, 1'b0},
    '{ROW_QUERY, 8'd0,   16'd20,    16'd60000, 1'b0, 1'b0},
    '{ROW_QUERY, 8'd0,   16'd150,   16'd150,   1'b0, 1'b0}
  };

  initial begin : stimulus
    int cx, cy, spread, count, nq;
    logic [15:0] qx, qy;
    foreach (shadow_x[i]) begin
      shadow_x[i] = '0;
      shadow_y[i] = '0;
    end
    shadow_geo = GEO_POINT;
    shadow_count = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed rows, no idling.
    foreach (directed[r]) begin
      if (directed[r].kind == ROW_CFG) begin
        idle_bus();
        write_register(directed[r].idx[CFG_ADDR_BITS-1:0], directed[r].x[7:0]);
      end else
        send_request(directed[r].kind == ROW_QUERY, directed[r].idx, directed[r].x,
                     directed[r].y, directed[r].has_exp, directed[r].exp_inside);
    end

    // Random shapes: write a ring, set registers while idle, then query around it.
    while (items_sent < RANDOM_ITEMS) begin
      case ((items_sent * 4 / RANDOM_ITEMS) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase
      if ($urandom_range(9) == 0) begin
        // now and then stretch over the whole coordinate range
        cx = 32768; cy = 32768; spread = 32767;
      end else begin
        spread = $urandom_range(2000, 10);
        cx = $urandom_range(65535 - spread, spread);
        cy = $urandom_range(65535 - spread, spread);
      end
      count = ($urandom_range(19) == 0) ? 0 : $urandom_range(12, 1);
      for (int v = 0; v < count; v++)
        send_request(1'b0, 8'(v), 16'($urandom_range(cx + spread, cx - spread)),
                     16'($urandom_range(cy + spread, cy - spread)), 1'b0, 1'b0);
      // noise writes beyond the ring
      if ($urandom_range(3) == 0)
        send_request(1'b0, 8'($urandom_range(255, 13)), 16'($urandom), 16'($urandom),
                     1'b0, 1'b0);
      idle_bus();
      write_register(REG_GEOMETRY_TYPE, 8'($urandom_range(3)));
      write_register(REG_VERTEX_COUNT, 8'(count));
      nq = $urandom_range(12, 4);
      for (int q = 0; q < nq; q++) begin
        case ($urandom_range(3))
          0: begin qx = shadow_x[0]; qy = shadow_y[0]; end
          1: begin qx = 16'($urandom); qy = 16'($urandom); end
          default: begin
            qx = 16'($urandom_range(cx + spread, cx - spread));
            qy = 16'($urandom_range(cy + spread, cy - spread));
          end
        endcase
        send_request(1'b1, 8'($urandom), qx, qy, 1'b0, 1'b0);
      end
    end

    // Write every table entry, then query a 255-vertex ring, the largest count.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int v = 0; v < 256; v++)
      send_request(1'b0, 8'(v), 16'($urandom), 16'($urandom), 1'b0, 1'b0);
    idle_bus();
    write_register(REG_GEOMETRY_TYPE, 8'(GEO_POLYGON));
    write_register(REG_VERTEX_COUNT, 8'd255);
    repeat (4) send_request(1'b1, 8'($urandom), 16'($urandom), 16'($urandom), 1'b0, 1'b0);
    idle_bus();

    while (inside_queue.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("Covered %0d requests: %0d vertex writes, %0d queries, %0d answers (%0d inside).",
             items_sent, writes_sent, queries_sent, results_seen, insides_seen);
    $display("All geometry types, counts 0 to 255, and four idle/stall phases exercised.");
    if (fail_count == 0 && inside_queue.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

// File: point_in_polygon_test.f
src/pip_pkg.sv
src/pip_ram.sv
src/point_in_polygon_test.sv
test/tb.sv
